// ===== rtl/core/spq_pkg.sv =====
package spq_pkg;

  // Storage geometry.
  localparam int CAPACITY = 16;
  localparam int KEY_BITS = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Port widths fixed by the interface.
  localparam int PORT_KEY_W   = 32;
  localparam int PORT_CNT_W   = 5;
  localparam int STATUS_W     = 2;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Commands.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Result status codes.
  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  // One finished result handed from the core to the output stage.
  typedef struct packed {
    logic    valid;
    key_t    front;
    status_t status;
    cnt_t    count;
  } res_t;

  // True when key a must stand in front of key b.
  function automatic logic goes_before(key_t a, key_t b, logic descending);
    logic r;
    if (descending) begin
      r = a > b;
    end else begin
      r = a < b;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/spq_core.sv =====
module spq_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_cmd,
  input  spq_pkg::key_t in_key,
  input  logic          order_desc,
  output spq_pkg::res_t res,
  input  logic          res_ready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_PUT  = 3'd2;
  localparam logic [2:0] S_REM  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]          state_r, state_nxt;
  spq_pkg::cnt_t       count_r, count_nxt;
  spq_pkg::addr_t      pos_r, pos_nxt;
  spq_pkg::key_t       key_r, key_nxt;
  spq_pkg::key_t       front_r, front_nxt;
  spq_pkg::status_t    status_r, status_nxt;

  // Key store: one write port, one read port, registered read data.
  spq_pkg::key_t       mem [spq_pkg::CAPACITY];
  spq_pkg::key_t       rdata_r;
  logic                we;
  spq_pkg::addr_t      wa;
  spq_pkg::key_t       wd;
  spq_pkg::addr_t      ra;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[ra];
  end

  logic accept;
  logic key_first;
  logic more;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign key_first = spq_pkg::goes_before(key_r, rdata_r, order_desc);
  assign more      = (spq_pkg::CNT_W'(pos_r) + spq_pkg::CNT_W'(1)) < count_r;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    key_nxt    = key_r;
    front_nxt  = front_r;
    status_nxt = status_r;
    we         = 1'b0;
    wa         = pos_r + spq_pkg::ADDR_W'(1);
    wd         = rdata_r;
    ra         = pos_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt    = in_key;
          front_nxt  = '0;
          status_nxt = spq_pkg::ST_DONE;
          if (in_cmd == spq_pkg::CMD_INSERT) begin
            if (count_r == spq_pkg::CNT_W'(spq_pkg::CAPACITY)) begin
              status_nxt = spq_pkg::ST_FULL;
              state_nxt  = S_FIN;
            end else if (count_r == '0) begin
              we        = 1'b1;
              wa        = '0;
              wd        = in_key;
              count_nxt = count_r + spq_pkg::CNT_W'(1);
              state_nxt = S_FIN;
            end else begin
              ra        = spq_pkg::ADDR_W'(count_r - spq_pkg::CNT_W'(1));
              pos_nxt   = ra;
              state_nxt = S_INS;
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = spq_pkg::ST_EMPTY;
              state_nxt  = S_FIN;
            end else begin
              ra        = '0;
              pos_nxt   = '0;
              state_nxt = S_REM;
            end
          end
        end
      end

      // rdata_r holds entry pos_r; the new key sits in the hole at pos_r + 1.
      S_INS: begin
        we = 1'b1;
        wa = pos_r + spq_pkg::ADDR_W'(1);
        if (key_first) begin
          wd = rdata_r;
          if (pos_r == '0) begin
            state_nxt = S_PUT;
          end else begin
            ra      = pos_r - spq_pkg::ADDR_W'(1);
            pos_nxt = ra;
          end
        end else begin
          wd        = key_r;
          count_nxt = count_r + spq_pkg::CNT_W'(1);
          state_nxt = S_FIN;
        end
      end

      S_PUT: begin
        we        = 1'b1;
        wa        = '0;
        wd        = key_r;
        count_nxt = count_r + spq_pkg::CNT_W'(1);
        state_nxt = S_FIN;
      end

      // rdata_r holds entry pos_r; it moves one place toward the front.
      S_REM: begin
        if (pos_r == '0) begin
          front_nxt = rdata_r;
        end else begin
          we = 1'b1;
          wa = pos_r - spq_pkg::ADDR_W'(1);
          wd = rdata_r;
        end
        if (more) begin
          ra      = pos_r + spq_pkg::ADDR_W'(1);
          pos_nxt = ra;
        end else begin
          count_nxt = count_r - spq_pkg::CNT_W'(1);
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    pos_r    <= pos_nxt;
    key_r    <= key_nxt;
    front_r  <= front_nxt;
    status_r <= status_nxt;
  end

  assign res.valid  = (state_r == S_FIN);
  assign res.front  = front_r;
  assign res.status = status_r;
  assign res.count  = count_r;

endmodule

// ===== rtl/core/sorted_array_priority_queue.sv =====
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    in_cmd, in_key
// out      output     out_valid/out_ready  out_front_key, out_status, out_count_after
// cfg      input      cfg_wr_en            cfg_wr_data (order_descending)
//
// An insert walks the key store from the back, and a remove from the front, at one
// entry per cycle through its single read port; an insert into an empty store and a
// rejected beat need no walk.
// Reset is synchronous and active low; it empties the store and selects ascending
// order. A result waiting in the output register does not stop the next input
// beat; only the handoff of the following result waits for out_ready.
module sorted_array_priority_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [31:0] in_key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_front_key,
  output logic [1:0]  out_status,
  output logic [4:0]  out_count_after,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  // Order select: 0 keeps the smallest key at the front, 1 the largest.
  logic order_descending_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_descending_r <= 1'b0;
    end else if (cfg_wr_en) begin
      order_descending_r <= cfg_wr_data;
    end
  end

  spq_pkg::res_t res;
  logic          res_ready;

  // The core owns the key store and the fill count and walks the store one entry per
  // cycle for inserts into a store that is neither empty nor full and removes from a non-empty store.
  spq_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .in_key     (spq_pkg::key_t'(in_key)),
    .order_desc (order_descending_r),
    .res        (res),
    .res_ready  (res_ready)
  );

  // Output register. It takes a new result whenever it is empty or its
  // current beat leaves in the same cycle.
  logic                          out_valid_r, out_valid_nxt;
  logic [spq_pkg::PORT_KEY_W-1:0] front_key_r;
  spq_pkg::status_t              status_r;
  logic [spq_pkg::PORT_CNT_W-1:0] count_after_r;

  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res.valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res.valid && res_ready) begin
      front_key_r   <= spq_pkg::PORT_KEY_W'(res.front);
      status_r      <= res.status;
      count_after_r <= spq_pkg::PORT_CNT_W'(res.count);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_front_key   = front_key_r;
  assign out_status      = status_r;
  assign out_count_after = count_after_r;

endmodule
